[hw/rtl/assert_macros.svh]
// Assertion helpers shared by the RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define FCJ_ASSERT_IMPL(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("fcj: same-cycle check failed");

// Next-cycle implication, disabled while reset is asserted.
`define FCJ_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("fcj: next-cycle check failed");

`endif

[hw/rtl/fcj_pkg.sv]
package fcj_pkg;

    // Window and judgement constants.
    localparam logic [31:0] NEAR_TIME  = 32'd60;
    localparam logic [31:0] GAP_BLOCKS = 32'd1;
    localparam logic [7:0]  NEVER_TOL  = 8'd255;
    localparam logic [7:0]  TOL_ONE    = 8'd16;

    // Job queue between the front and the judge.
    localparam int QDEPTH = 4;
    localparam int QAW    = $clog2(QDEPTH);
    localparam int QCW    = $clog2(QDEPTH + 1);

    // Configuration register indexes.
    typedef enum logic [2:0] {
        CFG_SMALL_SIZE    = 3'd0,
        CFG_BIG_SIZE      = 3'd1,
        CFG_TOLERANCES    = 3'd2,
        CFG_YOUNG_AGE     = 3'd3,
        CFG_OLD_AGE       = 3'd4,
        CFG_MAX_FRAGMENTS = 3'd5,
        CFG_MAX_CRUMBS    = 3'd6,
        CFG_MAX_DEVIANCE  = 3'd7
    } cfg_reg_t;

    // One record to judge, with its ideal position already worked out.
    typedef struct packed {
        logic [31:0] start;
        logic [31:0] age;
        logic [15:0] frags;
        logic [15:0] crumbs;
        logic [47:0] size;
        logic        regular;
        logic [31:0] ideal;
        logic        last;
    } job_t;

    // Up to two jobs written per accepted word, first one oldest.
    typedef struct packed {
        logic en0;
        logic en1;
        job_t job0;
        job_t job1;
    } qwr_t;

endpackage

[hw/rtl/fcj_front.sv]
module fcj_front (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  logic           q_full,
    input  logic [31:0]    extent_start,
    input  logic [31:0]    extent_end,
    input  logic [31:0]    block_count,
    input  logic [31:0]    access_time,
    input  logic [31:0]    file_age,
    input  logic [15:0]    fragment_count,
    input  logic [15:0]    crumb_count,
    input  logic [47:0]    size_bytes,
    input  logic           is_regular,
    input  logic           is_last,
    output fcj_pkg::qwr_t  qwr
);

    logic        accept;

    logic        prev_valid_reg, prev_valid_next;
    logic [31:0] prev_end_reg, prev_end_next;
    logic [31:0] prev_access_reg, prev_access_next;
    logic        held_valid_reg, held_valid_next;

    logic [31:0] held_start_reg;
    logic [31:0] held_end_reg;
    logic [31:0] held_atime_reg;
    logic [31:0] held_age_reg;
    logic [15:0] held_frags_reg;
    logic [15:0] held_crumbs_reg;
    logic [47:0] held_size_reg;
    logic        held_regular_reg;

    // Ideal start position from the neighbors that are close in access time.
    function automatic logic [31:0] ideal_calc(
        input logic [31:0] y_start,
        input logic [31:0] y_atime,
        input logic        p_ok,
        input logic [31:0] p_end,
        input logic [31:0] p_atime,
        input logic        n_ok,
        input logic [31:0] n_start,
        input logic [31:0] n_blocks,
        input logic [31:0] n_atime
    );
        logic [31:0] dp;
        logic [31:0] dn;
        logic [31:0] mid;
        logic        use_p;
        logic        use_n;
        dp    = (p_atime > y_atime) ? (p_atime - y_atime) : (y_atime - p_atime);
        dn    = (n_atime > y_atime) ? (n_atime - y_atime) : (y_atime - n_atime);
        use_p = p_ok && (p_end != 32'd0) && (dp < fcj_pkg::NEAR_TIME);
        use_n = n_ok && (n_start != 32'd0) && (dn < fcj_pkg::NEAR_TIME);
        mid   = p_end + n_start;
        if (y_start == 32'd0)
        begin
            return 32'd0;
        end
        if (use_p && use_n)
        begin
            return {1'b0, mid[31:1]};
        end
        if (use_p)
        begin
            return p_end + fcj_pkg::GAP_BLOCKS;
        end
        if (use_n)
        begin
            return n_start - n_blocks - fcj_pkg::GAP_BLOCKS;
        end
        return 32'd0;
    endfunction

    assign accept = push && !q_full;

    // Jobs: the held record judged against the incoming one, and on the last
    // word the incoming record judged with no next neighbor.
    always_comb
    begin
        qwr.en0          = accept && held_valid_reg;
        qwr.en1          = accept && is_last;

        qwr.job0.start   = held_start_reg;
        qwr.job0.age     = held_age_reg;
        qwr.job0.frags   = held_frags_reg;
        qwr.job0.crumbs  = held_crumbs_reg;
        qwr.job0.size    = held_size_reg;
        qwr.job0.regular = held_regular_reg;
        qwr.job0.last    = 1'b0;
        qwr.job0.ideal   = ideal_calc(held_start_reg, held_atime_reg,
                                      prev_valid_reg, prev_end_reg, prev_access_reg,
                                      1'b1, extent_start, block_count, access_time);

        qwr.job1.start   = extent_start;
        qwr.job1.age     = file_age;
        qwr.job1.frags   = fragment_count;
        qwr.job1.crumbs  = crumb_count;
        qwr.job1.size    = size_bytes;
        qwr.job1.regular = is_regular;
        qwr.job1.last    = 1'b1;
        qwr.job1.ideal   = ideal_calc(extent_start, access_time,
                                      held_valid_reg, held_end_reg, held_atime_reg,
                                      1'b0, 32'd0, 32'd0, 32'd0);
    end

    // Window shift; a last word clears the window.
    always_comb
    begin
        prev_valid_next  = prev_valid_reg;
        prev_end_next    = prev_end_reg;
        prev_access_next = prev_access_reg;
        held_valid_next  = held_valid_reg;
        if (accept)
        begin
            if (is_last)
            begin
                prev_valid_next = 1'b0;
                held_valid_next = 1'b0;
            end
            else
            begin
                prev_valid_next  = held_valid_reg;
                prev_end_next    = held_end_reg;
                prev_access_next = held_atime_reg;
                held_valid_next  = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_valid_reg <= 1'b0;
            held_valid_reg <= 1'b0;
        end
        else
        begin
            prev_valid_reg <= prev_valid_next;
            held_valid_reg <= held_valid_next;
        end
    end

    // Window payload, qualified by the valid bits above.
    always_ff @(posedge clk)
    begin
        prev_end_reg    <= prev_end_next;
        prev_access_reg <= prev_access_next;
        if (accept && !is_last)
        begin
            held_start_reg   <= extent_start;
            held_end_reg     <= extent_end;
            held_atime_reg   <= access_time;
            held_age_reg     <= file_age;
            held_frags_reg   <= fragment_count;
            held_crumbs_reg  <= crumb_count;
            held_size_reg    <= size_bytes;
            held_regular_reg <= is_regular;
        end
    end

`include "assert_macros.svh"

    `FCJ_ASSERT_NEXT(a_last_clears_window, clk, rst_n, accept && is_last, !held_valid_reg && !prev_valid_reg)
    `FCJ_ASSERT_IMPL(a_prev_needs_held, clk, rst_n, prev_valid_reg, held_valid_reg)

endmodule

[hw/rtl/fcj_queue.sv]
module fcj_queue (
    input  logic           clk,
    input  logic           rst_n,
    input  fcj_pkg::qwr_t  qwr,
    output logic           q_full,
    output logic           q_valid,
    output fcj_pkg::job_t  q_head,
    input  logic           q_pop
);

    fcj_pkg::job_t               mem [fcj_pkg::QDEPTH];
    logic [fcj_pkg::QAW-1:0]     wptr_reg, wptr_next;
    logic [fcj_pkg::QAW-1:0]     rptr_reg, rptr_next;
    logic [fcj_pkg::QCW-1:0]     cnt_reg, cnt_next;
    logic [fcj_pkg::QCW-1:0]     n_wr;
    logic [fcj_pkg::QAW-1:0]     waddr1;

    // Room for two jobs is needed before a word is taken.
    assign q_full  = cnt_reg > fcj_pkg::QCW'(fcj_pkg::QDEPTH - 2);
    assign q_valid = cnt_reg != '0;
    assign q_head  = mem[rptr_reg];

    assign n_wr   = fcj_pkg::QCW'(qwr.en0) + fcj_pkg::QCW'(qwr.en1);
    assign waddr1 = qwr.en0 ? (wptr_reg + fcj_pkg::QAW'(1)) : wptr_reg;

    // Pointer and fill count update.
    always_comb
    begin
        wptr_next = wptr_reg + fcj_pkg::QAW'(n_wr);
        rptr_next = q_pop ? (rptr_reg + fcj_pkg::QAW'(1)) : rptr_reg;
        cnt_next  = cnt_reg + n_wr - fcj_pkg::QCW'(q_pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg <= '0;
            rptr_reg <= '0;
            cnt_reg  <= '0;
        end
        else
        begin
            wptr_reg <= wptr_next;
            rptr_reg <= rptr_next;
            cnt_reg  <= cnt_next;
        end
    end

    // Storage, written in arrival order.
    always_ff @(posedge clk)
    begin
        if (qwr.en0)
        begin
            mem[wptr_reg] <= qwr.job0;
        end
        if (qwr.en1)
        begin
            mem[waddr1] <= qwr.job1;
        end
    end

`include "assert_macros.svh"

    `FCJ_ASSERT_IMPL(a_cnt_bound, clk, rst_n, 1'b1, cnt_reg <= fcj_pkg::QCW'(fcj_pkg::QDEPTH))
    `FCJ_ASSERT_IMPL(a_no_pop_empty, clk, rst_n, q_pop, q_valid)

endmodule

[hw/rtl/fcj_judge.sv]
module fcj_judge (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           cfg_valid,
    input  logic [2:0]     cfg_index,
    input  logic [47:0]    cfg_data,
    input  logic           q_valid,
    input  fcj_pkg::job_t  q_head,
    output logic           q_pop,
    input  logic           pop,
    output logic           empty,
    output logic           guilty,
    output logic [31:0]    ideal_position,
    output logic           last_result
);

    // Configuration registers.
    logic [47:0] small_size_reg;
    logic [47:0] big_size_reg;
    logic [15:0] tolerances_reg;
    logic [31:0] young_age_reg;
    logic [31:0] old_age_reg;
    logic [15:0] max_fragments_reg;
    logic [15:0] max_crumbs_reg;
    logic [31:0] max_deviance_reg;

    // Pipeline handshake.
    logic s1_v_reg, s1_v_next;
    logic s2_v_reg, s2_v_next;
    logic out_v_reg, out_v_next;
    logic out_free, s2_free, s1_free;

    // Stage 1: tolerance selection and deviance magnitude.
    logic [7:0]  tol_c;
    logic [31:0] dev_d;
    logic [7:0]  s1_tol_reg;
    logic        s1_ok_reg;
    logic        s1_dev_en_reg;
    logic [31:0] s1_age_reg;
    logic [15:0] s1_frags_reg;
    logic [15:0] s1_crumbs_reg;
    logic [31:0] s1_mag_reg;
    logic [31:0] s1_ideal_reg;
    logic        s1_last_reg;

    // Stage 2: limits scaled by the tolerance.
    logic        s2_ok_reg;
    logic        s2_dev_en_reg;
    logic [31:0] s2_age_reg;
    logic [15:0] s2_frags_reg;
    logic [15:0] s2_crumbs_reg;
    logic [31:0] s2_mag_reg;
    logic [31:0] s2_ideal_reg;
    logic        s2_last_reg;
    logic [39:0] s2_young_lim_reg;
    logic [39:0] s2_old_lim_reg;
    logic [23:0] s2_frag_lim_reg;
    logic [23:0] s2_crumb_lim_reg;
    logic [39:0] s2_dev_lim_reg;

    // Stage 3: comparisons into the result register.
    logic        guilty_c;
    logic [39:0] age_x16;
    logic [23:0] frags_x16;
    logic [23:0] crumbs_x16;
    logic [39:0] mag_x16;
    logic        guilty_reg;
    logic [31:0] ideal_reg;
    logic        last_reg;

    // Register writes; the port is always ready.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            small_size_reg    <= 48'd0;
            big_size_reg      <= 48'd0;
            tolerances_reg    <= 16'h1010;
            young_age_reg     <= 32'd0;
            old_age_reg       <= 32'hFFFF_FFFF;
            max_fragments_reg <= 16'hFFFF;
            max_crumbs_reg    <= 16'hFFFF;
            max_deviance_reg  <= 32'd0;
        end
        else if (cfg_valid)
        begin
            unique case (fcj_pkg::cfg_reg_t'(cfg_index))
                fcj_pkg::CFG_SMALL_SIZE:    small_size_reg    <= cfg_data;
                fcj_pkg::CFG_BIG_SIZE:      big_size_reg      <= cfg_data;
                fcj_pkg::CFG_TOLERANCES:    tolerances_reg    <= cfg_data[15:0];
                fcj_pkg::CFG_YOUNG_AGE:     young_age_reg     <= cfg_data[31:0];
                fcj_pkg::CFG_OLD_AGE:       old_age_reg       <= cfg_data[31:0];
                fcj_pkg::CFG_MAX_FRAGMENTS: max_fragments_reg <= cfg_data[15:0];
                fcj_pkg::CFG_MAX_CRUMBS:    max_crumbs_reg    <= cfg_data[15:0];
                fcj_pkg::CFG_MAX_DEVIANCE:  max_deviance_reg  <= cfg_data[31:0];
                default: ;
            endcase
        end
    end

    // A stage advances when the one after it is free or moving on.
    always_comb
    begin
        out_free   = !out_v_reg || pop;
        s2_free    = !s2_v_reg || out_free;
        s1_free    = !s1_v_reg || s2_free;
        q_pop      = q_valid && s1_free;
        s1_v_next  = s1_free ? q_valid : s1_v_reg;
        s2_v_next  = s2_free ? s1_v_reg : s2_v_reg;
        out_v_next = out_free ? s2_v_reg : out_v_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_v_reg  <= 1'b0;
            s2_v_reg  <= 1'b0;
            out_v_reg <= 1'b0;
        end
        else
        begin
            s1_v_reg  <= s1_v_next;
            s2_v_reg  <= s2_v_next;
            out_v_reg <= out_v_next;
        end
    end

    // Tolerance from the size thresholds; the magnitude of the wrapped
    // difference fits 32 bits unsigned, the most negative value included.
    always_comb
    begin
        if ((small_size_reg != 48'd0) && (q_head.size < small_size_reg))
        begin
            tol_c = tolerances_reg[7:0];
        end
        else if ((big_size_reg != 48'd0) && (q_head.size > big_size_reg))
        begin
            tol_c = tolerances_reg[15:8];
        end
        else
        begin
            tol_c = fcj_pkg::TOL_ONE;
        end
        dev_d = q_head.start - q_head.ideal;
    end

    always_ff @(posedge clk)
    begin
        if (s1_free)
        begin
            s1_tol_reg    <= tol_c;
            s1_ok_reg     <= q_head.regular && (tol_c != fcj_pkg::NEVER_TOL);
            s1_dev_en_reg <= (max_deviance_reg != 32'd0) && (q_head.start != 32'd0)
                             && (q_head.ideal != 32'd0);
            s1_age_reg    <= q_head.age;
            s1_frags_reg  <= q_head.frags;
            s1_crumbs_reg <= q_head.crumbs;
            s1_mag_reg    <= dev_d[31] ? (32'd0 - dev_d) : dev_d;
            s1_ideal_reg  <= q_head.ideal;
            s1_last_reg   <= q_head.last;
        end
    end

    // Scaled limits, one 32 or 16 by 8 product each.
    always_ff @(posedge clk)
    begin
        if (s2_free)
        begin
            s2_ok_reg        <= s1_ok_reg;
            s2_dev_en_reg    <= s1_dev_en_reg;
            s2_age_reg       <= s1_age_reg;
            s2_frags_reg     <= s1_frags_reg;
            s2_crumbs_reg    <= s1_crumbs_reg;
            s2_mag_reg       <= s1_mag_reg;
            s2_ideal_reg     <= s1_ideal_reg;
            s2_last_reg      <= s1_last_reg;
            s2_young_lim_reg <= 40'(young_age_reg) * 40'(s1_tol_reg);
            s2_old_lim_reg   <= 40'(old_age_reg) * 40'(s1_tol_reg);
            s2_frag_lim_reg  <= 24'(max_fragments_reg) * 24'(s1_tol_reg);
            s2_crumb_lim_reg <= 24'(max_crumbs_reg) * 24'(s1_tol_reg);
            s2_dev_lim_reg   <= 40'(max_deviance_reg) * 40'(s1_tol_reg);
        end
    end

    // Irregular, NEVER_TOL or young pass; any exceeded limit is guilty.
    always_comb
    begin
        age_x16    = {4'd0, s2_age_reg, 4'd0};
        frags_x16  = {4'd0, s2_frags_reg, 4'd0};
        crumbs_x16 = {4'd0, s2_crumbs_reg, 4'd0};
        mag_x16    = {4'd0, s2_mag_reg, 4'd0};
        guilty_c   = s2_ok_reg && !(age_x16 < s2_young_lim_reg)
                     && ((age_x16 > s2_old_lim_reg)
                         || (frags_x16 > s2_frag_lim_reg)
                         || (crumbs_x16 > s2_crumb_lim_reg)
                         || (s2_dev_en_reg && (mag_x16 > s2_dev_lim_reg)));
    end

    always_ff @(posedge clk)
    begin
        if (out_free)
        begin
            guilty_reg <= guilty_c;
            ideal_reg  <= s2_ideal_reg;
            last_reg   <= s2_last_reg;
        end
    end

    assign empty          = !out_v_reg;
    assign guilty         = guilty_reg;
    assign ideal_position = ideal_reg;
    assign last_result    = last_reg;

`include "assert_macros.svh"

    `FCJ_ASSERT_NEXT(a_s1_holds, clk, rst_n, s1_v_reg && !s2_free, s1_v_reg)
    `FCJ_ASSERT_NEXT(a_s2_holds, clk, rst_n, s2_v_reg && !out_free, s2_v_reg)

endmodule

[hw/rtl/fragmentation_candidate_judge.sv]
// A job is shown (empty low) after the queue, stage 1, stage 2 and result registers.
// Throughput: one word per cycle while full is low; the judge delivers one result per
// cycle while pop keeps up; the queue absorbs the second job of an is_last word.
// full rises when the four-entry job queue has less than two free entries.
// Reset (rst_n, asynchronous, active low) empties window, queue and pipeline and loads
// the register defaults; configuration writes are taken in every cycle.
module fragmentation_candidate_judge (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    output logic        full,
    input  logic [31:0] extent_start,
    input  logic [31:0] extent_end,
    input  logic [31:0] block_count,
    input  logic [31:0] access_time,
    input  logic [31:0] file_age,
    input  logic [15:0] fragment_count,
    input  logic [15:0] crumb_count,
    input  logic [47:0] size_bytes,
    input  logic        is_regular,
    input  logic        is_last,
    output logic        empty,
    input  logic        pop,
    output logic        guilty,
    output logic [31:0] ideal_position,
    output logic        last_result,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [47:0] cfg_data
);

    fcj_pkg::qwr_t qwr;
    fcj_pkg::job_t q_head;
    logic          q_full;
    logic          q_valid;
    logic          q_pop;

    assign cfg_ready = 1'b1;
    assign full      = q_full;

    // Front: record window and ideal position.
    fcj_front u_front (
        .clk            (clk),
        .rst_n          (rst_n),
        .push           (push),
        .q_full         (q_full),
        .extent_start   (extent_start),
        .extent_end     (extent_end),
        .block_count    (block_count),
        .access_time    (access_time),
        .file_age       (file_age),
        .fragment_count (fragment_count),
        .crumb_count    (crumb_count),
        .size_bytes     (size_bytes),
        .is_regular     (is_regular),
        .is_last        (is_last),
        .qwr            (qwr)
    );

    // Job queue between front and judge.
    fcj_queue u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .qwr     (qwr),
        .q_full  (q_full),
        .q_valid (q_valid),
        .q_head  (q_head),
        .q_pop   (q_pop)
    );

    // Judge pipeline and configuration registers.
    fcj_judge u_judge (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_valid      (cfg_valid),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .q_valid        (q_valid),
        .q_head         (q_head),
        .q_pop          (q_pop),
        .pop            (pop),
        .empty          (empty),
        .guilty         (guilty),
        .ideal_position (ideal_position),
        .last_result    (last_result)
    );

endmodule
